// ===== rtl/core/vdi_pkg.sv =====
package vdi_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int WORDS_PER_VTX   = 8;
    localparam int WORD_W          = 32;
    localparam int VERTEX_W        = WORDS_PER_VTX * WORD_W;
    localparam int INDEX_W         = 8;
    localparam int UCOUNT_W        = 9;
    localparam int OUT_TDATA_W     = 24;
    localparam int OUT_TUSER_W     = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // status of the table read pipe as seen by the sequencer
    typedef struct packed {
        logic rd_valid;
        logic hit;
    } t_tbl_stat;

endpackage

// ===== rtl/core/vdi_table.sv =====
module vdi_table #(
    parameter int TABLE_DEPTH = vdi_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [IDX_W-1:0]          i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [IDX_W-1:0]          i_wr_addr,
    input  logic [vdi_pkg::VERTEX_W-1:0] i_key,
    output vdi_pkg::t_tbl_stat        o_stat,
    output logic [IDX_W-1:0]          o_hit_slot
);
    import vdi_pkg::*;

    logic [VERTEX_W-1:0] mem [TABLE_DEPTH];
    logic [VERTEX_W-1:0] r_rd_data;
    logic [IDX_W-1:0]    r_rd_slot;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_key;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_slot <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_rd_en;
        end
    end

    // compare the entry fetched last cycle against the held key
    assign o_stat.rd_valid = r_rd_valid;
    assign o_stat.hit      = r_rd_valid && (r_rd_data == i_key);
    assign o_hit_slot      = r_rd_slot;

endmodule

// ===== rtl/core/vertex_dedup_indexer.sv =====
// One item is handled at a time: an input beat is taken in ST_IDLE and compared in ST_SCAN
// against the N entries stored before it, stopping at the first hit (at most TABLE_DEPTH
// entries); its result is loaded into the output register from ST_DONE once that is free.
// The single table read port scans one entry per cycle; an empty table needs no read.
// A new input beat is taken while the previous result waits on the output register.
// Reset (synchronous, active low) empties the table; entries need no clearing.
module vertex_dedup_indexer #(
    parameter int TABLE_DEPTH = vdi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
    input  logic [vdi_pkg::VERTEX_W-1:0]   i_s_tdata,
    input  logic                           i_s_tlast,   // last_corner
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // vertex_index [7:0], unique_count [16:8], zero [23:17]
    output logic [vdi_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // is_new [0], overflow [1]
    output logic [vdi_pkg::OUT_TUSER_W-1:0] o_m_tuser
);
    import vdi_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_state              r_state, n_state;
    logic [VERTEX_W-1:0] r_key;
    logic                r_last;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_scan;
    logic [IDX_W-1:0]    r_res_idx;
    logic                r_res_new;
    logic                r_res_ovf;
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_idx;
    logic [UCOUNT_W-1:0] r_out_cnt;
    logic                r_out_new;
    logic                r_out_ovf;

    t_tbl_stat           tbl_stat;
    logic [IDX_W-1:0]    hit_slot;
    logic                s_ready;
    logic                rd_en;
    logic                wr_en;
    logic                scan_miss;
    logic                table_full;
    logic                out_free;
    logic                load_out;
    logic [IDX_W+INDEX_W-1:0]    idx_ext;
    logic [CNT_W+UCOUNT_W-1:0]   cnt_ext;

    assign table_full = (r_count == CNT_W'(TABLE_DEPTH));
    assign out_free   = !r_out_valid || i_m_tready;
    assign scan_miss  = !tbl_stat.hit && !tbl_stat.rd_valid && (r_scan >= r_count);

    vdi_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_scan[IDX_W-1:0]),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_count[IDX_W-1:0]),
        .i_key      (r_key),
        .o_stat     (tbl_stat),
        .o_hit_slot (hit_slot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (tbl_stat.hit || scan_miss) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: s_ready = 1'b1;
            ST_SCAN: begin
                rd_en = !tbl_stat.hit && (r_scan < r_count);
                wr_en = scan_miss && !table_full;
            end
            ST_DONE: load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN && wr_en) begin
                r_count <= r_count + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
                // drop the table after the last corner of a model
                if (r_last) r_count <= '0;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_tvalid) begin
            r_key  <= i_s_tdata;
            r_last <= i_s_tlast;
            r_scan <= '0;
        end else if (rd_en) begin
            r_scan <= r_scan + 1'b1;
        end
        if (r_state == ST_SCAN) begin
            if (tbl_stat.hit) begin
                r_res_idx <= hit_slot;
                r_res_new <= 1'b0;
                r_res_ovf <= 1'b0;
            end else if (scan_miss) begin
                r_res_idx <= table_full ? '0 : r_count[IDX_W-1:0];
                r_res_new <= !table_full;
                r_res_ovf <= table_full;
            end
        end
    end

    assign idx_ext = {{INDEX_W{1'b0}}, r_res_idx};
    assign cnt_ext = {{UCOUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_idx <= idx_ext[INDEX_W-1:0];
            r_out_cnt <= cnt_ext[UCOUNT_W-1:0];
            r_out_new <= r_res_new;
            r_out_ovf <= r_res_ovf;
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - INDEX_W - UCOUNT_W){1'b0}}, r_out_cnt, r_out_idx};
    assign o_m_tuser  = {r_out_ovf, r_out_new};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("stored count beyond table depth");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !table_full && !tbl_stat.hit)
        else $error("append into full table or on a hit");

    a_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && r_res_ovf |-> !r_res_new && r_res_idx == '0)
        else $error("overflow result carries an append");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && wr_en) |=> r_state == ST_DONE && r_res_new)
        else $error("append not followed by result");
`endif

endmodule
